// File: hdl/pf_pkg.sv
// Shared types, constants and helper functions for the Playfair digram decipher.
package pf_pkg;

  // Key square geometry.
  localparam int Side     = 5;
  localparam int Cells    = Side * Side;
  localparam int LetterW  = 5;
  localparam int PosW     = $clog2(Cells);
  localparam int CoordW   = $clog2(Side);

  // Configuration register layout.
  localparam int FieldW   = 60;
  localparam int CellsLow = FieldW / LetterW;
  localparam int CellsMid = FieldW / LetterW;
  localparam int CfgIdxW  = 2;

  // Default depth of the queue between front and back.
  localparam int QueueDepthDefault = 4;

  // Register indexes of the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    REG_LOW  = 2'd0,
    REG_MID  = 2'd1,
    REG_LAST = 2'd2
  } cfg_reg_t;

  typedef logic [LetterW-1:0] letter_t;
  typedef logic [PosW-1:0]    pos_t;
  typedef logic [CoordW-1:0]  coord_t;
  typedef letter_t [Cells-1:0] square_t;

  // One ciphertext digram as it arrives.
  typedef struct packed {
    letter_t cipher_first;
    letter_t cipher_second;
    logic    final_pair;
  } digram_t;

  // One deciphered digram as it leaves.
  typedef struct packed {
    letter_t plain_first;
    letter_t plain_second;
    logic    pair_invalid;
    logic    final_out;
  } result_t;

  // Classified digram handed from the front to the back.
  typedef struct packed {
    pos_t qa;
    pos_t qb;
    logic invalid;
    logic last_pair;
  } work_t;

  // Row of a square position, found by range compares instead of a divide.
  function automatic coord_t pos_row(input pos_t pos);
    coord_t row;
    row = '0;
    for (int r = 1; r < Side; r++) begin
      if (pos >= pos_t'(r * Side)) begin
        row = coord_t'(r);
      end
    end
    return row;
  endfunction

  // Column of a square position, given its row.
  function automatic coord_t pos_col(input pos_t pos, input coord_t row);
    pos_t base;
    base = pos_t'(row) * pos_t'(Side);
    return coord_t'(pos - base);
  endfunction

  // Position from row and column.
  function automatic pos_t make_pos(input coord_t row, input coord_t col);
    return pos_t'(pos_t'(row) * pos_t'(Side) + pos_t'(col));
  endfunction

  // Step one place back along a row or column, wrapping to the far end.
  function automatic coord_t step_back(input coord_t v);
    return (v == '0) ? coord_t'(Side - 1) : coord_t'(v - coord_t'(1));
  endfunction

endpackage

// File: hdl/playfair_digram_decipher_top.sv
// Path: a transferred digram is written to the queue, then loaded into the result register.
// Throughput: one digram per cycle while results are popped; locate logic is combinational.
// With the default four-entry queue, five digrams transfer while no result is popped: four
// wait in the queue and one in the result register.
// Reset (rst, synchronous, active high) empties the queue and result register and clears the
// key square to all zero (every position holds A).
module playfair_digram_decipher_top #(
  parameter int QueueDepth = pf_pkg::QueueDepthDefault
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  pf_pkg::digram_t             digram,
  output logic                        empty,
  input  logic                        pop,
  output pf_pkg::result_t             result,
  input  logic                        cfg_write,
  input  logic [pf_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [pf_pkg::FieldW-1:0]   cfg_data
);

  logic [pf_pkg::FieldW-1:0]  sq_low;
  logic [pf_pkg::FieldW-1:0]  sq_mid;
  pf_pkg::letter_t            sq_last;
  pf_pkg::square_t            square;
  logic                       queue_write;
  logic                       queue_full;
  logic                       queue_valid;
  logic                       work_take;
  pf_pkg::work_t              front_work;
  pf_pkg::work_t              queue_head;

  // Configuration registers; writes to an unused index are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_low  <= '0;
      sq_mid  <= '0;
      sq_last <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        pf_pkg::REG_LOW:  sq_low  <= cfg_data;
        pf_pkg::REG_MID:  sq_mid  <= cfg_data;
        pf_pkg::REG_LAST: sq_last <= cfg_data[pf_pkg::LetterW-1:0];
        default: ;
      endcase
    end
  end

  // Unpack the three registers into the 25-position square.
  always_comb begin
    for (int p = 0; p < pf_pkg::CellsLow; p++) begin
      square[p] = sq_low[p * pf_pkg::LetterW +: pf_pkg::LetterW];
    end
    for (int p = 0; p < pf_pkg::CellsMid; p++) begin
      square[pf_pkg::CellsLow + p] = sq_mid[p * pf_pkg::LetterW +: pf_pkg::LetterW];
    end
    square[pf_pkg::Cells - 1] = sq_last;
  end

  assign full = queue_full;

  pf_front u_front (
    .square      (square),
    .push        (push),
    .digram      (digram),
    .queue_full  (queue_full),
    .queue_write (queue_write),
    .work        (front_work)
  );

  pf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (queue_write),
    .wr_data (front_work),
    .full    (queue_full),
    .rd      (work_take),
    .valid   (queue_valid),
    .rd_data (queue_head)
  );

  pf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .square     (square),
    .work_valid (queue_valid),
    .work       (queue_head),
    .work_take  (work_take),
    .pop        (pop),
    .empty      (empty),
    .result     (result)
  );

endmodule

// File: hdl/pf_front.sv
// Front end: takes digrams, locates both letters in the square and classifies the pair.
module pf_front (
  input  pf_pkg::square_t square,
  input  logic            push,
  input  pf_pkg::digram_t digram,
  input  logic            queue_full,
  output logic            queue_write,
  output pf_pkg::work_t   work
);

  logic          found_a;
  logic          found_b;
  pf_pkg::pos_t  pa;
  pf_pkg::pos_t  pb;
  pf_pkg::coord_t ra;
  pf_pkg::coord_t ca;
  pf_pkg::coord_t rb;
  pf_pkg::coord_t cb;
  logic          bad;

  // An item transfers whenever the queue has room.
  assign queue_write = push && !queue_full;

  // Lowest position holding each letter; scanning downward lets the lowest match win.
  always_comb begin
    found_a = 1'b0;
    found_b = 1'b0;
    pa      = '0;
    pb      = '0;
    for (int p = pf_pkg::Cells - 1; p >= 0; p--) begin
      if (square[p] == digram.cipher_first) begin
        found_a = 1'b1;
        pa      = pf_pkg::pos_t'(p);
      end
      if (square[p] == digram.cipher_second) begin
        found_b = 1'b1;
        pb      = pf_pkg::pos_t'(p);
      end
    end
  end

  // Row and column of both letters.
  always_comb begin
    ra = pf_pkg::pos_row(pa);
    ca = pf_pkg::pos_col(pa, ra);
    rb = pf_pkg::pos_row(pb);
    cb = pf_pkg::pos_col(pb, rb);
  end

  assign bad = !found_a || !found_b || (pa == pb);

  // Target positions by the Playfair rules.
  always_comb begin
    work.invalid   = bad;
    work.last_pair = digram.final_pair;
    if (bad) begin
      work.qa = '0;
      work.qb = '0;
    end else if (ra == rb) begin
      work.qa = pf_pkg::make_pos(ra, pf_pkg::step_back(ca));
      work.qb = pf_pkg::make_pos(rb, pf_pkg::step_back(cb));
    end else if (ca == cb) begin
      work.qa = pf_pkg::make_pos(pf_pkg::step_back(ra), ca);
      work.qb = pf_pkg::make_pos(pf_pkg::step_back(rb), cb);
    end else begin
      work.qa = pf_pkg::make_pos(ra, cb);
      work.qb = pf_pkg::make_pos(rb, ca);
    end
  end

endmodule

// File: hdl/pf_queue.sv
// Small queue of classified digrams between the front and the back.
module pf_queue #(
  parameter int Depth = pf_pkg::QueueDepthDefault
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  pf_pkg::work_t wr_data,
  output logic          full,
  input  logic          rd,
  output logic          valid,
  output pf_pkg::work_t rd_data
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  pf_pkg::work_t   slots [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic [CntW-1:0] count_next;
  logic            do_wr;
  logic            do_rd;

  assign full    = (count == FullCnt);
  assign valid   = (count != '0);
  assign rd_data = slots[rd_ptr];
  assign do_wr   = wr && !full;
  assign do_rd   = rd && valid;

  // Occupancy follows the two transfers.
  always_comb begin
    count_next = count;
    if (do_wr && !do_rd) begin
      count_next = count + CntW'(1);
    end else if (do_rd && !do_wr) begin
      count_next = count - CntW'(1);
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + PtrW'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // Occupancy never passes the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FullCnt) else $error("queue occupancy beyond depth");

  // A lone write into an empty queue makes it non-empty on the next cycle.
  a_write_shows: assert property (@(posedge clk) disable iff (rst)
    (wr && !valid) |=> valid) else $error("written entry not visible");

endmodule

// File: hdl/pf_back.sv
// Back end: reads the target letters from the square and holds the result register.
module pf_back (
  input  logic            clk,
  input  logic            rst,
  input  pf_pkg::square_t square,
  input  logic            work_valid,
  input  pf_pkg::work_t   work,
  output logic            work_take,
  input  logic            pop,
  output logic            empty,
  output pf_pkg::result_t result
);

  logic out_valid;

  assign empty = !out_valid;

  // Load a new result whenever the register is free or being drained.
  assign work_take = work_valid && (!out_valid || pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (work_take) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload; an invalid pair gives zero letters.
  always_ff @(posedge clk) begin
    if (work_take) begin
      result.plain_first  <= work.invalid ? '0 : square[work.qa];
      result.plain_second <= work.invalid ? '0 : square[work.qb];
      result.pair_invalid <= work.invalid;
      result.final_out    <= work.last_pair;
    end
  end

  // A waiting result that is not taken stays unchanged.
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pop) |=> $stable(result)) else $error("result changed while waiting");

  // An invalid pair carries zero letters.
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result.pair_invalid) |-> (result.plain_first == '0 &&
      result.plain_second == '0)) else $error("invalid pair with letters");

endmodule
